/* rtl/lips_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the result slot table for the link indicator
// and poll scheduler. No dependencies.
package lips_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int NOW_WIDTH      = 32;
  localparam int CFG_WIDTH      = 32;
  localparam int CFG_ADDR_WIDTH = 3;

  // register indexes
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_BLINK_PERIOD = 3'd0;
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_BLINK_GRACE  = 3'd1;
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_PROBE_PERIOD = 3'd2;
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_BOOT_WAIT    = 3'd3;
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_SYNC_PERIOD  = 3'd4;
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_FETCH_PERIOD = 3'd5;

  localparam logic [CFG_WIDTH-1:0] RST_BLINK_PERIOD = 32'd500;
  localparam logic [CFG_WIDTH-1:0] RST_BLINK_GRACE  = 32'd30000;
  localparam logic [CFG_WIDTH-1:0] RST_PROBE_PERIOD = 32'd30000;
  localparam logic [CFG_WIDTH-1:0] RST_BOOT_WAIT    = 32'd1000;
  localparam logic [CFG_WIDTH-1:0] RST_SYNC_PERIOD  = 32'd86400000;
  localparam logic [CFG_WIDTH-1:0] RST_FETCH_PERIOD = 32'd600000;

  // command codes
  localparam logic [2:0] CMD_NONE          = 3'd0;
  localparam logic [2:0] CMD_PING          = 3'd1;
  localparam logic [2:0] CMD_GET_LINK      = 3'd2;
  localparam logic [2:0] CMD_SYNC_TIME     = 3'd3;
  localparam logic [2:0] CMD_GET_WEATHER   = 3'd4;
  localparam logic [2:0] CMD_FETCH_WEATHER = 3'd5;

  // weather display actions
  localparam logic [1:0] WACT_NONE  = 2'd0;
  localparam logic [1:0] WACT_SHOW  = 2'd1;
  localparam logic [1:0] WACT_BLANK = 2'd2;

  localparam logic OP_STEP   = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  // result slots, emitted lowest first
  localparam int NUM_SLOTS = 10;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int SLOT_PROBE       = 0;
  localparam int SLOT_BOOT_PING   = 1;
  localparam int SLOT_BOOT_LINK   = 2;
  localparam int SLOT_BOOT_SYNC   = 3;
  localparam int SLOT_BOOT_WTHR   = 4;
  localparam int SLOT_SYNC_LINK   = 5;
  localparam int SLOT_SYNC_TIME   = 6;
  localparam int SLOT_FETCH_LINK  = 7;
  localparam int SLOT_FETCH_WTHR  = 8;
  localparam int SLOT_IDLE        = 9;

  function automatic logic [2:0] slot_command(input logic [SLOT_W-1:0] slot);
    logic [2:0] cmd;
    unique case (slot)
      SLOT_W'(SLOT_PROBE):      cmd = CMD_GET_LINK;
      SLOT_W'(SLOT_BOOT_PING):  cmd = CMD_PING;
      SLOT_W'(SLOT_BOOT_LINK):  cmd = CMD_GET_LINK;
      SLOT_W'(SLOT_BOOT_SYNC):  cmd = CMD_SYNC_TIME;
      SLOT_W'(SLOT_BOOT_WTHR):  cmd = CMD_GET_WEATHER;
      SLOT_W'(SLOT_SYNC_LINK):  cmd = CMD_GET_LINK;
      SLOT_W'(SLOT_SYNC_TIME):  cmd = CMD_SYNC_TIME;
      SLOT_W'(SLOT_FETCH_LINK): cmd = CMD_GET_LINK;
      SLOT_W'(SLOT_FETCH_WTHR): cmd = CMD_FETCH_WEATHER;
      default:                  cmd = CMD_NONE;
    endcase
    return cmd;
  endfunction

  typedef struct packed {
    logic [CFG_WIDTH-1:0] blink_period;
    logic [CFG_WIDTH-1:0] blink_grace;
    logic [CFG_WIDTH-1:0] probe_period;
    logic [CFG_WIDTH-1:0] boot_wait;
    logic [CFG_WIDTH-1:0] sync_period;
    logic [CFG_WIDTH-1:0] fetch_period;
  } cfg_t;

  typedef struct packed {
    logic                 opcode;
    logic [NOW_WIDTH-1:0] now_time;
    logic                 link_connected;
    logic                 weather_valid;
  } item_t;

  // everything the emitter needs for one request's results
  typedef struct packed {
    logic [NUM_SLOTS-1:0] mask;
    logic                 icon;
    logic [1:0]           wact;
  } run_t;

endpackage

/* rtl/lips_ifs.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces: input items, results, register writes.
// Depends on lips_pkg.
interface lips_item_if import lips_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 opcode;
  logic [NOW_WIDTH-1:0] now_time;
  logic                 link_connected;
  logic                 weather_valid;
  modport source (output valid, opcode, now_time, link_connected, weather_valid,
                  input ready);
  modport sink   (input valid, opcode, now_time, link_connected, weather_valid,
                  output ready);
endinterface

interface lips_result_if import lips_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic       icon_visible;
  logic [1:0] weather_action;
  logic       last_of_run;
  modport source (output valid, command, icon_visible, weather_action, last_of_run,
                  input ready);
  modport sink   (input valid, command, icon_visible, weather_action, last_of_run,
                  output ready);
endinterface

interface lips_cfg_if import lips_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CFG_ADDR_WIDTH-1:0] addr;
  logic [CFG_WIDTH-1:0]      data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

/* rtl/lips_cfg_regs.sv */
`timescale 1ns / 1ps
// Configuration register file, written over the cfg channel.
// Depends on lips_pkg and lips_ifs.
module lips_cfg_regs import lips_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  lips_cfg_if.sink    cfg,
  output cfg_t        regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.blink_period <= RST_BLINK_PERIOD;
      regs.blink_grace  <= RST_BLINK_GRACE;
      regs.probe_period <= RST_PROBE_PERIOD;
      regs.boot_wait    <= RST_BOOT_WAIT;
      regs.sync_period  <= RST_SYNC_PERIOD;
      regs.fetch_period <= RST_FETCH_PERIOD;
    end else if (cfg.valid) begin
      unique case (cfg.addr)
        CFG_BLINK_PERIOD: regs.blink_period <= cfg.data;
        CFG_BLINK_GRACE:  regs.blink_grace  <= cfg.data;
        CFG_PROBE_PERIOD: regs.probe_period <= cfg.data;
        CFG_BOOT_WAIT:    regs.boot_wait    <= cfg.data;
        CFG_SYNC_PERIOD:  regs.sync_period  <= cfg.data;
        CFG_FETCH_PERIOD: regs.fetch_period <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/lips_in_reg.sv */
`timescale 1ns / 1ps
// Input holding register: captures one request, frees when the scheduler
// consumes it. Depends on lips_pkg and lips_ifs.
module lips_in_reg import lips_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  lips_item_if.sink item,
  input  logic      load,
  output logic      held_valid,
  output item_t     held
);

  assign item.ready = !held_valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      held_valid <= 1'b1;
    end else if (load) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      held.opcode         <= item.opcode;
      held.now_time       <= item.now_time;
      held.link_connected <= item.link_connected;
      held.weather_valid  <= item.weather_valid;
    end
  end

endmodule

/* rtl/lips_sched.sv */
`timescale 1ns / 1ps
// Link/poll state and the single-pass decision logic for one request.
// Depends on lips_pkg.
module lips_sched import lips_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  item_t held,
  input  logic  load,
  output run_t  run_new
);

  localparam int CW = (TIME_WIDTH > CFG_WIDTH) ? TIME_WIDTH : CFG_WIDTH;

  logic                  status_known, status_known_next;
  logic                  link_up, link_up_next;
  logic                  icon_on, icon_on_next;
  logic                  boot_done, boot_done_next;
  logic [TIME_WIDTH-1:0] down_since, down_since_next;
  logic [TIME_WIDTH-1:0] blink_time, blink_time_next;
  logic [TIME_WIDTH-1:0] probe_time, probe_time_next;
  logic [TIME_WIDTH-1:0] sync_mark, sync_mark_next;
  logic [TIME_WIDTH-1:0] fetch_time, fetch_time_next;

  logic [TIME_WIDTH-1:0] now;
  logic [TIME_WIDTH-1:0] sync_base, fetch_base;
  logic                  probe_fire, boot_fire, sync_fire, fetch_fire;

  // elapsed time (wrapping) reached a 32-bit period
  function automatic logic reached(input logic [TIME_WIDTH-1:0] t,
                                   input logic [TIME_WIDTH-1:0] base,
                                   input logic [CFG_WIDTH-1:0]  period);
    logic [TIME_WIDTH-1:0] d;
    d = t - base;
    return CW'(d) >= CW'(period);
  endfunction

  assign now = TIME_WIDTH'(held.now_time);

  always_comb begin
    status_known_next = status_known;
    link_up_next      = link_up;
    icon_on_next      = icon_on;
    boot_done_next    = boot_done;
    down_since_next   = down_since;
    blink_time_next   = blink_time;
    probe_time_next   = probe_time;
    sync_mark_next    = sync_mark;
    fetch_time_next   = fetch_time;
    run_new           = '0;
    probe_fire        = 1'b0;
    boot_fire         = 1'b0;
    sync_fire         = 1'b0;
    fetch_fire        = 1'b0;
    sync_base         = sync_mark;
    fetch_base        = fetch_time;

    if (held.opcode == OP_REPORT) begin
      run_new.wact = WACT_NONE;
      if (!status_known || held.link_connected != link_up) begin
        status_known_next = 1'b1;
        link_up_next      = held.link_connected;
        icon_on_next      = 1'b1;
        if (held.link_connected) begin
          run_new.wact = held.weather_valid ? WACT_SHOW : WACT_NONE;
        end else begin
          down_since_next = now;
          blink_time_next = now;
          run_new.wact    = WACT_BLANK;
        end
      end
      run_new.mask[SLOT_IDLE] = 1'b1;
    end else begin
      if (status_known) begin
        if (link_up || !reached(now, down_since, cfg.blink_grace)) begin
          icon_on_next = 1'b1;
        end else if (reached(now, blink_time, cfg.blink_period)) begin
          blink_time_next = now;
          icon_on_next    = !icon_on;
        end
      end

      probe_fire = (!status_known || !link_up) &&
                   reached(now, probe_time, cfg.probe_period);
      boot_fire  = !boot_done && (CW'(now) > CW'(cfg.boot_wait));
      // boot burst restarts the sync and fetch timers before they are checked
      sync_base  = boot_fire ? now : sync_mark;
      fetch_base = boot_fire ? now : fetch_time;
      sync_fire  = reached(now, sync_base, cfg.sync_period);
      fetch_fire = reached(now, fetch_base, cfg.fetch_period);

      if (boot_fire) begin
        boot_done_next = 1'b1;
      end
      if (sync_fire) begin
        sync_mark_next = now;
      end else if (boot_fire) begin
        sync_mark_next = now;
      end
      if (fetch_fire || boot_fire) begin
        fetch_time_next = now;
      end
      if (probe_fire || boot_fire || sync_fire || fetch_fire) begin
        probe_time_next = now;
      end

      run_new.mask[SLOT_PROBE]      = probe_fire;
      run_new.mask[SLOT_BOOT_PING]  = boot_fire;
      run_new.mask[SLOT_BOOT_LINK]  = boot_fire;
      run_new.mask[SLOT_BOOT_SYNC]  = boot_fire;
      run_new.mask[SLOT_BOOT_WTHR]  = boot_fire;
      run_new.mask[SLOT_SYNC_LINK]  = sync_fire;
      run_new.mask[SLOT_SYNC_TIME]  = sync_fire;
      run_new.mask[SLOT_FETCH_LINK] = fetch_fire;
      run_new.mask[SLOT_FETCH_WTHR] = fetch_fire;
      run_new.mask[SLOT_IDLE]       = !(probe_fire || boot_fire || sync_fire || fetch_fire);
    end
    run_new.icon = icon_on_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status_known <= 1'b0;
      link_up      <= 1'b0;
      icon_on      <= 1'b1;
      boot_done    <= 1'b0;
      down_since   <= '0;
      blink_time   <= '0;
      probe_time   <= '0;
      sync_mark    <= '0;
      fetch_time   <= '0;
    end else if (load) begin
      status_known <= status_known_next;
      link_up      <= link_up_next;
      icon_on      <= icon_on_next;
      boot_done    <= boot_done_next;
      down_since   <= down_since_next;
      blink_time   <= blink_time_next;
      probe_time   <= probe_time_next;
      sync_mark    <= sync_mark_next;
      fetch_time   <= fetch_time_next;
    end
  end

endmodule

/* rtl/lips_emit.sv */
`timescale 1ns / 1ps
// Result register: holds one request's pending result slots and hands them
// out lowest slot first. Depends on lips_pkg and lips_ifs.
module lips_emit import lips_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  run_t          run_new,
  input  logic          held_valid,
  output logic          load,
  lips_result_if.source result
);

  logic [NUM_SLOTS-1:0] mask;
  logic                 icon;
  logic [1:0]           wact;
  logic [SLOT_W-1:0]    slot;
  logic                 last;

  always_comb begin
    slot = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (mask[i]) slot = SLOT_W'(i);
    end
  end

  assign last = (mask & (mask - NUM_SLOTS'(1))) == '0;
  assign load = held_valid && (!result.valid || (result.ready && last));

  assign result.valid          = |mask;
  assign result.command        = slot_command(slot);
  assign result.icon_visible   = icon;
  assign result.weather_action = wact;
  assign result.last_of_run    = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (load) begin
      mask <= run_new.mask;
    end else if (result.valid && result.ready) begin
      mask <= mask & (mask - NUM_SLOTS'(1));  // drop lowest pending slot
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      icon <= run_new.icon;
      wact <= run_new.wact;
    end
  end

endmodule

/* rtl/link_indicator_poll_scheduler_core.sv */
`timescale 1ns / 1ps
// Channel    Dir  Handshake    Payload
// item       in   valid/ready  opcode, now_time, link_connected, weather_valid
// result     out  valid/ready  command, icon_visible, weather_action, last_of_run
// cfg        in   valid/ready  addr (register index), data
//
// A request is captured in the input register, decided in one pass and loaded
// into the result register, which gives 1 to 9 results, one a cycle while the
// receiver is ready; a request that gives one result then sustains one request
// per cycle, else one result per cycle, set by the single result register.
// Reset (rst, synchronous) clears the link state and loads register defaults.
// A stalled result holds; the input register still takes one request meanwhile.
// Depends on lips_pkg, lips_ifs and the lips_* modules.
module link_indicator_poll_scheduler_core import lips_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  lips_cfg_if.sink      cfg,
  lips_item_if.sink     item,
  lips_result_if.source result
);

  cfg_t  regs;
  item_t held;
  run_t  run_new;
  logic  held_valid;
  logic  load;

  lips_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  lips_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .load       (load),
    .held_valid (held_valid),
    .held       (held)
  );

  lips_sched #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_sched (
    .clk     (clk),
    .rst     (rst),
    .cfg     (regs),
    .held    (held),
    .load    (load),
    .run_new (run_new)
  );

  lips_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .run_new    (run_new),
    .held_valid (held_valid),
    .load       (load),
    .result     (result)
  );

endmodule

/* bench/link_indicator_poll_scheduler_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for link_indicator_poll_scheduler_core: directed table, then random
// time-stamped requests under several idle/stall mixes, checked against an in-bench predictor.
// Depends on lips_pkg, lips_ifs and the core RTL.
module link_indicator_poll_scheduler_core_tb;
  import lips_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_REQUESTS = 85;
  localparam int unsigned PHASES = 4;
  localparam int unsigned SRC_IDLE_PCT[PHASES] = '{0, 67, 0, 31};
  localparam int unsigned SINK_STALL_PCT[PHASES] = '{0, 0, 67, 31};
  // indexes past the register list; writes there must be dropped
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [2:0] command;
    logic       icon_visible;
    logic [1:0] weather_action;
    logic       last_of_run;
  } indicator_result_t;

  typedef enum {ROW_WRITE, ROW_CHECKED, ROW_FIXED} row_kind_t;

  typedef struct {
    row_kind_t                 kind;
    item_t                     req;
    logic [CFG_ADDR_WIDTH-1:0] addr;
    logic [CFG_WIDTH-1:0]      data;
    indicator_result_t         want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  lips_item_if   item_ch();
  lips_result_if result_ch();
  lips_cfg_if    cfg_ch();

  link_indicator_poll_scheduler_core uut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .item   (item_ch),
    .result (result_ch)
  );

  always #5 clk = ~clk;

  // predictor state
  cfg_t regs = '{RST_BLINK_PERIOD, RST_BLINK_GRACE, RST_PROBE_PERIOD,
                 RST_BOOT_WAIT, RST_SYNC_PERIOD, RST_FETCH_PERIOD};
  logic        lnk_known = 1'b0;
  logic        lnk_up    = 1'b0;
  logic        icon_lit  = 1'b1;
  logic        booted    = 1'b0;
  logic [31:0] down_at   = '0;
  logic [31:0] blink_at  = '0;
  logic [31:0] probe_at  = '0;
  logic [31:0] sync_at   = '0;
  logic [31:0] fetch_at  = '0;

  indicator_result_t pending[$];
  stim_row_t         script[$];
  int unsigned       mismatches = 0;
  int unsigned       cycle = 0;
  int unsigned       hold_until = 0;
  int unsigned       src_pct = 0;
  int unsigned       sink_pct = 0;
  logic [31:0]       tick_clock = 32'd50000;

  function automatic logic [31:0] ticks_since(logic [31:0] now, logic [31:0] mark);
    return now - mark;
  endfunction

  function automatic void advance_model(input item_t req, ref indicator_result_t res[$]);
    logic [2:0]        cmds[$];
    logic [1:0]        wact;
    logic [31:0]       now;
    indicator_result_t r;
    now = req.now_time;
    wact = WACT_NONE;
    res.delete();
    if (req.opcode == OP_REPORT) begin
      if (!lnk_known || req.link_connected != lnk_up) begin
        lnk_known = 1'b1;
        lnk_up = req.link_connected;
        icon_lit = 1'b1;
        if (req.link_connected) begin
          wact = req.weather_valid ? WACT_SHOW : WACT_NONE;
        end else begin
          down_at = now;
          blink_at = now;
          wact = WACT_BLANK;
        end
      end
      cmds.push_back(CMD_NONE);
    end else begin
      if (lnk_known) begin
        if (lnk_up || ticks_since(now, down_at) < regs.blink_grace) begin
          icon_lit = 1'b1;
        end else if (ticks_since(now, blink_at) >= regs.blink_period) begin
          blink_at = now;
          icon_lit = !icon_lit;
        end
      end
      if ((!lnk_known || !lnk_up) && ticks_since(now, probe_at) >= regs.probe_period) begin
        cmds.push_back(CMD_GET_LINK);
        probe_at = now;
      end
      // boot test is a plain unsigned compare, no wrap
      if (!booted && now > regs.boot_wait) begin
        cmds.push_back(CMD_PING);
        cmds.push_back(CMD_GET_LINK);
        cmds.push_back(CMD_SYNC_TIME);
        cmds.push_back(CMD_GET_WEATHER);
        probe_at = now;
        booted = 1'b1;
        sync_at = now;
        fetch_at = now;
      end
      if (ticks_since(now, sync_at) >= regs.sync_period) begin
        cmds.push_back(CMD_GET_LINK);
        cmds.push_back(CMD_SYNC_TIME);
        probe_at = now;
        sync_at = now;
      end
      if (ticks_since(now, fetch_at) >= regs.fetch_period) begin
        cmds.push_back(CMD_GET_LINK);
        cmds.push_back(CMD_FETCH_WEATHER);
        probe_at = now;
        fetch_at = now;
      end
      if (cmds.size() == 0) cmds.push_back(CMD_NONE);
    end
    foreach (cmds[k]) begin
      r.command = cmds[k];
      r.icon_visible = icon_lit;
      r.weather_action = wact;
      r.last_of_run = (k == cmds.size() - 1);
      res.push_back(r);
    end
  endfunction

  function automatic void note_mismatch(string what, indicator_result_t want,
                                        indicator_result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s: expected cmd=%0d icon=%0b wact=%0d last=%0b,",
               $realtime, what, want.command, want.icon_visible, want.weather_action,
               want.last_of_run,
               " got cmd=%0d icon=%0b wact=%0d last=%0b",
               got.command, got.icon_visible, got.weather_action, got.last_of_run);
    end
  endfunction

  // table builders
  function automatic void add_write(logic [CFG_ADDR_WIDTH-1:0] addr, logic [CFG_WIDTH-1:0] data);
    stim_row_t row;
    row.kind = ROW_WRITE;
    row.req = '0;
    row.addr = addr;
    row.data = data;
    row.want = '0;
    script.push_back(row);
  endfunction

  function automatic void add_reg_set(cfg_t c);
    add_write(CFG_BLINK_PERIOD, c.blink_period);
    add_write(CFG_BLINK_GRACE, c.blink_grace);
    add_write(CFG_PROBE_PERIOD, c.probe_period);
    add_write(CFG_BOOT_WAIT, c.boot_wait);
    add_write(CFG_SYNC_PERIOD, c.sync_period);
    add_write(CFG_FETCH_PERIOD, c.fetch_period);
  endfunction

  function automatic void add_item(logic op, logic [31:0] now, logic conn, logic wv);
    stim_row_t row;
    row.kind = ROW_CHECKED;
    row.req = '{opcode: op, now_time: now, link_connected: conn, weather_valid: wv};
    row.addr = '0;
    row.data = '0;
    row.want = '0;
    script.push_back(row);
  endfunction

  // single-result request whose outcome is written out by hand
  function automatic void add_fixed(logic op, logic [31:0] now, logic conn, logic wv,
                                    logic [2:0] cmd, logic icon, logic [1:0] wact);
    stim_row_t row;
    row.kind = ROW_FIXED;
    row.req = '{opcode: op, now_time: now, link_connected: conn, weather_valid: wv};
    row.addr = '0;
    row.data = '0;
    row.want = '{command: cmd, icon_visible: icon, weather_action: wact, last_of_run: 1'b1};
    script.push_back(row);
  endfunction

  task automatic offer_item(input item_t req, input bit fixed, input indicator_result_t want);
    indicator_result_t runs[$];
    while ($urandom_range(0, 99) < src_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.opcode <= req.opcode;
    item_ch.now_time <= req.now_time;
    item_ch.link_connected <= req.link_connected;
    item_ch.weather_valid <= req.weather_valid;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    advance_model(req, runs);
    if (fixed) begin
      pending.push_back(want);
    end else begin
      foreach (runs[k]) pending.push_back(runs[k]);
    end
  endtask

  task automatic write_reg(input logic [CFG_ADDR_WIDTH-1:0] addr,
                           input logic [CFG_WIDTH-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr <= addr;
    cfg_ch.data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (addr)
      CFG_BLINK_PERIOD: regs.blink_period = data;
      CFG_BLINK_GRACE:  regs.blink_grace = data;
      CFG_PROBE_PERIOD: regs.probe_period = data;
      CFG_BOOT_WAIT:    regs.boot_wait = data;
      CFG_SYNC_PERIOD:  regs.sync_period = data;
      CFG_FETCH_PERIOD: regs.fetch_period = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // must be called in the step of the last acceptance
  task automatic drain();
    item_ch.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_period(int unsigned hi);
    if ($urandom_range(0, 7) == 0) return 32'd0;
    return 32'($urandom_range(1, hi));
  endfunction

  task automatic random_item();
    item_t       req;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      // noise: arbitrary time stamp and fields
      req.opcode = 1'($urandom_range(0, 1));
      req.now_time = $urandom;
    end else begin
      if (roll < 13) tick_clock += 32'($urandom_range(5000, 40000));
      else tick_clock += 32'($urandom_range(0, 900));
      req.opcode = ($urandom_range(0, 99) < 20) ? OP_REPORT : OP_STEP;
      req.now_time = tick_clock;
    end
    req.link_connected = 1'($urandom_range(0, 1));
    req.weather_valid = 1'($urandom_range(0, 1));
    offer_item(req, 1'b0, '0);
  endtask

  // result receiver
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst || cycle < hold_until) result_ch.ready <= 1'b0;
      else result_ch.ready <= ($urandom_range(0, 99) >= sink_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    indicator_result_t got;
    indicator_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.command = result_ch.command;
      got.icon_visible = result_ch.icon_visible;
      got.weather_action = result_ch.weather_action;
      got.last_of_run = result_ch.last_of_run;
      if (pending.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else begin
        want = pending.pop_front();
        if (got.command !== want.command || got.icon_visible !== want.icon_visible ||
            got.weather_action !== want.weather_action ||
            got.last_of_run !== want.last_of_run) begin
          note_mismatch("result mismatch", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("link_indicator_poll_scheduler_core test failed");
      $finish;
    end
  end

  initial begin
    cfg_t c;
    rst <= 1'b1;
    item_ch.valid <= 1'b0;
    item_ch.opcode <= OP_STEP;
    item_ch.now_time <= '0;
    item_ch.link_connected <= 1'b0;
    item_ch.weather_valid <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.addr <= CFG_BLINK_PERIOD;
    cfg_ch.data <= '0;

    // reset defaults, status unknown; boot needs now strictly above boot_wait
    add_fixed(OP_STEP, 32'd0, 1'b0, 1'b0, CMD_NONE, 1'b1, WACT_NONE);
    add_fixed(OP_STEP, 32'd1000, 1'b0, 1'b0, CMD_NONE, 1'b1, WACT_NONE);
    add_fixed(OP_REPORT, 32'd1000, 1'b1, 1'b1, CMD_NONE, 1'b1, WACT_SHOW);
    add_fixed(OP_REPORT, 32'd1000, 1'b1, 1'b1, CMD_NONE, 1'b1, WACT_NONE);
    add_fixed(OP_REPORT, 32'd2000, 1'b0, 1'b1, CMD_NONE, 1'b1, WACT_BLANK);
    add_fixed(OP_REPORT, 32'd2000, 1'b0, 1'b0, CMD_NONE, 1'b1, WACT_NONE);
    add_write(CFG_SPARE_LO, 32'd0);
    add_write(CFG_SPARE_HI, 32'hFFFF_FFFF);
    // zero periods: every event fires, first step gives the full nine results
    add_reg_set('0);
    add_item(OP_STEP, 32'd3000, 1'b1, 1'b1);
    add_item(OP_STEP, 32'd3000, 1'b0, 1'b0);
    add_reg_set('1);
    add_item(OP_STEP, 32'd3001, 1'b0, 1'b0);
    add_fixed(OP_REPORT, 32'd3002, 1'b1, 1'b0, CMD_NONE, 1'b1, WACT_NONE);
    add_item(OP_STEP, 32'hFFFF_FFFF, 1'b1, 1'b1);
    add_fixed(OP_REPORT, 32'hFFFF_FFFF, 1'b0, 1'b1, CMD_NONE, 1'b1, WACT_BLANK);
    add_item(OP_STEP, 32'd5, 1'b0, 1'b0);
    add_reg_set('{RST_BLINK_PERIOD, RST_BLINK_GRACE, RST_PROBE_PERIOD,
                  RST_BOOT_WAIT, RST_SYNC_PERIOD, RST_FETCH_PERIOD});
    // grace expired across the wrap: blink off, hold, blink on, then fetch
    add_item(OP_STEP, 32'd40000, 1'b0, 1'b0);
    add_item(OP_STEP, 32'd40499, 1'b0, 1'b0);
    add_item(OP_STEP, 32'd40500, 1'b0, 1'b0);
    add_item(OP_STEP, 32'd1000000, 1'b0, 1'b0);
    add_fixed(OP_REPORT, 32'd1000100, 1'b1, 1'b1, CMD_NONE, 1'b1, WACT_SHOW);
    add_fixed(OP_REPORT, 32'd1000200, 1'b1, 1'b0, CMD_NONE, 1'b1, WACT_NONE);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        if (i == 0 || script[i - 1].kind != ROW_WRITE) drain();
        write_reg(script[i].addr, script[i].data);
      end else begin
        offer_item(script[i].req, script[i].kind == ROW_FIXED, script[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      c.blink_period = pick_period(600);
      c.blink_grace = 32'($urandom_range(0, 4000));
      c.probe_period = pick_period(3000);
      c.boot_wait = $urandom;
      c.sync_period = pick_period(20000);
      c.fetch_period = pick_period(8000);
      write_reg(CFG_BLINK_PERIOD, c.blink_period);
      write_reg(CFG_BLINK_GRACE, c.blink_grace);
      write_reg(CFG_PROBE_PERIOD, c.probe_period);
      write_reg(CFG_BOOT_WAIT, c.boot_wait);
      write_reg(CFG_SYNC_PERIOD, c.sync_period);
      write_reg(CFG_FETCH_PERIOD, c.fetch_period);
      src_pct = SRC_IDLE_PCT[p];
      sink_pct = SINK_STALL_PCT[p];
      // long receiver hold while requests keep coming: core backs up
      if (p == 0) hold_until = cycle + 400;
      // run the last phase through the time stamp wrap
      if (p == PHASES - 1) tick_clock = 32'hFFFF_C000;
      repeat (PHASE_REQUESTS) random_item();
    end

    drain();
    if (pending.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("link_indicator_poll_scheduler_core test passed");
    end else begin
      $display("link_indicator_poll_scheduler_core test failed");
    end
    $finish;
  end

endmodule
